// ----- sv/ptw_pkg.sv -----
`timescale 1ns / 1ps
package ptw_pkg;

    // Table geometry
    localparam int ENTRIES_PER_TABLE = 512;
    localparam int TABLE_COUNT       = 16;
    localparam int IDX_W             = $clog2(ENTRIES_PER_TABLE);
    localparam int TBL_W             = $clog2(TABLE_COUNT);
    localparam int FREE_W            = $clog2(TABLE_COUNT + 1);
    localparam int STORE_DEPTH       = TABLE_COUNT * ENTRIES_PER_TABLE;
    localparam int ADDR_W            = $clog2(STORE_DEPTH);
    localparam int ENTRY_W           = 64;
    localparam int VA_W              = 48;
    localparam int PA_W              = 52;
    localparam int FLAGS_W           = 12;
    localparam int LEVEL_W           = 2;
    localparam logic [LEVEL_W-1:0] LEVEL_LAST = 2'd3;

    // Request commands
    localparam logic [1:0] CMD_MAP       = 2'd0;
    localparam logic [1:0] CMD_UNMAP     = 2'd1;
    localparam logic [1:0] CMD_TRANSLATE = 2'd2;
    localparam logic [1:0] CMD_NONE      = 2'd3;

    // Store write data select
    localparam logic [1:0] WR_ZERO = 2'd0;
    localparam logic [1:0] WR_LINK = 2'd1;
    localparam logic [1:0] WR_LEAF = 2'd2;

    // Result kinds
    localparam logic [1:0] RES_OK    = 2'd0;
    localparam logic [1:0] RES_FAIL  = 2'd1;
    localparam logic [1:0] RES_FRAME = 2'd2;

    typedef struct packed {
        logic [1:0]         command;
        logic [VA_W-1:0]    virt_addr;
        logic [PA_W-1:0]    frame_addr;
        logic [FLAGS_W-1:0] entry_flags;
        logic               exec_disable;
    } ptw_req_t;

    typedef struct packed {
        logic            success;
        logic [PA_W-1:0] phys_frame;
    } ptw_rsp_t;

    // Controller to datapath
    typedef struct packed {
        logic       clr_wr;
        logic       load_req;
        logic       mem_rd;
        logic       mem_wr;
        logic [1:0] wr_sel;
        logic       descend;
        logic       alloc;
        logic       set_res;
        logic [1:0] res_kind;
        logic       load_out;
    } ptw_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [1:0] command;
        logic       level_last;
        logic       present;
        logic       pool_empty;
        logic       clr_last;
    } ptw_sts_t;

endpackage

// ----- sv/ptw_ram.sv -----
`timescale 1ns / 1ps
module ptw_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8192
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Single port: write, or registered read
    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem_reg[addr] <= wdata;
            end else begin
                rdata_reg <= mem_reg[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/ptw_datapath.sv -----
`timescale 1ns / 1ps
module ptw_datapath (
    input  logic              aclk,
    input  logic              aresetn,
    input  ptw_pkg::ptw_req_t s_payload,
    input  ptw_pkg::ptw_cmd_t cmd,
    output ptw_pkg::ptw_sts_t sts,
    output ptw_pkg::ptw_rsp_t m_payload
);
    import ptw_pkg::*;

    ptw_req_t             req_reg;
    logic [TBL_W-1:0]     table_reg, table_next;
    logic [LEVEL_W-1:0]   level_reg, level_next;
    logic [FREE_W-1:0]    free_reg, free_next;
    logic [ADDR_W-1:0]    clr_reg, clr_next;
    ptw_rsp_t             res_reg, res_next;
    ptw_rsp_t             out_reg;

    logic [IDX_W-1:0]     idx;
    logic [ADDR_W-1:0]    walk_addr;
    logic                 ram_en;
    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_addr;
    logic [ENTRY_W-1:0]   ram_wdata;
    logic [ENTRY_W-1:0]   ram_rdata;
    logic [ENTRY_W-1:0]   link_word;
    logic [ENTRY_W-1:0]   leaf_word;
    logic                 child_ok;
    logic [TBL_W-1:0]     child;

    // Pick the index bits of the current level
    always_comb begin
        unique case (level_reg)
            2'd0:    idx = req_reg.virt_addr[47:39];
            2'd1:    idx = req_reg.virt_addr[38:30];
            2'd2:    idx = req_reg.virt_addr[29:21];
            default: idx = req_reg.virt_addr[20:12];
        endcase
    end

    assign walk_addr = ADDR_W'({table_reg, idx});

    // Decode a fetched upper entry
    assign child_ok = ram_rdata[0] &&
                      (ram_rdata[PA_W-1:12] < (PA_W - 12)'(TABLE_COUNT));
    assign child    = ram_rdata[12 +: TBL_W];

    // Build the entries that the walk writes
    assign link_word = {{(ENTRY_W - 12 - TBL_W){1'b0}}, free_reg[TBL_W-1:0], 10'b0, 2'b11};
    assign leaf_word = {req_reg.exec_disable, {(ENTRY_W - PA_W - 1){1'b0}},
                        req_reg.frame_addr[PA_W-1:12], req_reg.entry_flags[11:1], 1'b1};

    // Store port mux
    always_comb begin
        ram_en   = cmd.clr_wr | cmd.mem_rd | cmd.mem_wr;
        ram_we   = cmd.clr_wr | cmd.mem_wr;
        ram_addr = cmd.clr_wr ? clr_reg : walk_addr;
        unique case (cmd.wr_sel)
            WR_LINK: ram_wdata = link_word;
            WR_LEAF: ram_wdata = leaf_word;
            default: ram_wdata = '0;
        endcase
        if (cmd.clr_wr) begin
            ram_wdata = '0;
        end
    end

    ptw_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Advance the walk position and the table pool
    always_comb begin
        table_next = table_reg;
        level_next = level_reg;
        free_next  = free_reg;
        clr_next   = cmd.clr_wr ? clr_reg + 1'b1 : clr_reg;
        if (cmd.load_req) begin
            table_next = '0;
            level_next = '0;
        end else if (cmd.descend) begin
            table_next = child;
            level_next = level_reg + 1'b1;
        end else if (cmd.alloc) begin
            table_next = free_reg[TBL_W-1:0];
            level_next = level_reg + 1'b1;
            free_next  = free_reg + 1'b1;
        end
    end

    // Stage the result of the current request
    always_comb begin
        res_next = res_reg;
        if (cmd.set_res) begin
            res_next.success    = (cmd.res_kind != RES_FAIL);
            res_next.phys_frame = '0;
            if (cmd.res_kind == RES_FRAME && ram_rdata[0]) begin
                res_next.phys_frame = {ram_rdata[PA_W-1:12], 12'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_reg <= FREE_W'(1);
            clr_reg  <= '0;
        end else begin
            free_reg <= free_next;
            clr_reg  <= clr_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            req_reg <= s_payload;
        end
        if (cmd.load_out) begin
            out_reg <= res_reg;
        end
        table_reg <= table_next;
        level_reg <= level_next;
        res_reg   <= res_next;
    end

    assign sts.command    = req_reg.command;
    assign sts.level_last = (level_reg == LEVEL_LAST);
    assign sts.present    = child_ok;
    assign sts.pool_empty = (free_reg >= FREE_W'(TABLE_COUNT));
    assign sts.clr_last   = (clr_reg == ADDR_W'(STORE_DEPTH - 1));
    assign m_payload      = out_reg;

endmodule

// ----- sv/ptw_ctrl.sv -----
`timescale 1ns / 1ps
module ptw_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  ptw_pkg::ptw_sts_t sts,
    output ptw_pkg::ptw_cmd_t cmd
);
    import ptw_pkg::*;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_EVAL  = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       is_map;
    logic       is_unmap;

    assign is_map   = (sts.command == CMD_MAP);
    assign is_unmap = (sts.command == CMD_UNMAP);

    // Sequence the walk
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr_wr = 1'b1;
                if (sts.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_req = 1'b1;
                    state_next   = ST_READ;
                end
            end
            ST_READ: begin
                priority if (sts.command == CMD_NONE) begin
                    cmd.set_res  = 1'b1;
                    cmd.res_kind = RES_OK;
                    state_next   = ST_DONE;
                end else if (sts.level_last && (is_map || is_unmap)) begin
                    cmd.mem_wr   = 1'b1;
                    cmd.wr_sel   = is_map ? WR_LEAF : WR_ZERO;
                    cmd.set_res  = 1'b1;
                    cmd.res_kind = RES_OK;
                    state_next   = ST_DONE;
                end else begin
                    cmd.mem_rd = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                priority if (sts.level_last) begin
                    cmd.set_res  = 1'b1;
                    cmd.res_kind = RES_FRAME;
                    state_next   = ST_DONE;
                end else if (sts.present) begin
                    cmd.descend = 1'b1;
                    state_next  = ST_READ;
                end else if (is_map && !sts.pool_empty) begin
                    cmd.mem_wr = 1'b1;
                    cmd.wr_sel = WR_LINK;
                    cmd.alloc  = 1'b1;
                    state_next = ST_READ;
                end else begin
                    cmd.set_res  = 1'b1;
                    cmd.res_kind = is_map ? RES_FAIL : RES_OK;
                    state_next   = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold the result until the transfer completes
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// ----- sv/four_level_page_table_walker.sv -----
// A translate walks four levels, each a store read followed by an evaluation of
//   the registered read data (one store read port).
// One request at a time: the next input is taken only once the last result is loaded;
//   a finished result waits in the output register without blocking new input.
// Reset: synchronous, active low; a clearing pass over all 8192 store entries (one
//   entry per cycle) zeroes the table store before the first input is taken.
`timescale 1ns / 1ps
module four_level_page_table_walker (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ptw_pkg::ptw_req_t s_payload,
    output logic              m_valid,
    input  logic              m_ready,
    output ptw_pkg::ptw_rsp_t m_payload
);
    import ptw_pkg::*;

    ptw_cmd_t cmd;
    ptw_sts_t sts;

    ptw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    ptw_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_payload (s_payload),
        .cmd       (cmd),
        .sts       (sts),
        .m_payload (m_payload)
    );

`ifndef SYNTHESIS
    // One request in flight: busy right after each input transfer
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken while a walk is in flight");

    // Never take a table beyond the pool
    a_alloc_in_pool: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.alloc |-> !sts.pool_empty)
        else $error("table allocated from an exhausted pool");

    // Never overwrite a result still waiting for transfer
    a_no_result_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !cmd.load_out)
        else $error("pending result overwritten");

    // No input during the clearing pass
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clr_wr |-> !s_ready)
        else $error("input ready during store clear");
`endif

endmodule

// ----- sim/four_level_page_table_walker_tb.sv -----
`timescale 1ns / 1ps
module four_level_page_table_walker_tb;
    import ptw_pkg::*;

    localparam int          CYCLE_LIMIT = 400000;
    localparam int          TAIL_CYCLES = 32;
    localparam int          RAND_ITEMS  = 1450;
    localparam logic [63:0] FRAME_MASK  = 64'h000F_FFFF_FFFF_F000;
    localparam logic [63:0] ENT_PRESENT = 64'h0000_0000_0000_0001;
    localparam logic [63:0] ENT_WRITE   = 64'h0000_0000_0000_0002;
    localparam logic [63:0] ENT_NOEXEC  = 64'h8000_0000_0000_0000;

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    ptw_req_t s_payload;
    logic     m_valid;
    logic     m_ready;
    ptw_rsp_t m_payload;

    // Shadow copy of the table store and the bump pool
    logic [ENTRY_W-1:0] shadow_tables [STORE_DEPTH];
    int                 shadow_next_free;
    logic [VA_W-1:21]   leaf_regions [$];
    ptw_rsp_t           expected_rsp_q [$];

    int send_idle_pct;
    int recv_idle_pct;
    int mismatches  = 0;
    int cycle_count = 0;
    int n_map, n_map_refused, n_unmap, n_translate, n_frames_found, n_unused;

    four_level_page_table_walker i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Abort a run that never drains
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Stall the result channel at random
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
        mismatches++;
    endtask

    function automatic int slot_of(input int tbl, input logic [VA_W-1:0] va, input int lvl);
        logic [VA_W-1:0] idx;
        idx = (va >> (39 - 9 * lvl)) & 48'h1FF;
        return tbl * ENTRIES_PER_TABLE + int'(idx);
    endfunction

    // Follow an upper entry; absent or out-of-pool links count as missing
    function automatic bit child_table(input logic [63:0] entry, output int child);
        logic [63:0] num;
        num   = (entry & FRAME_MASK) >> 12;
        child = int'(num[TBL_W:0]);
        return entry[0] && (num < TABLE_COUNT);
    endfunction

    function automatic bit find_leaf_table(input logic [VA_W-1:0] va, output int tbl);
        int lvl;
        int child;
        tbl = 0;
        for (lvl = 0; lvl < 3; lvl++) begin
            if (!child_table(shadow_tables[slot_of(tbl, va, lvl)], child))
                return 1'b0;
            tbl = child;
        end
        return 1'b1;
    endfunction

    // Apply one request to the shadow tables and give the result it must produce
    function automatic ptw_rsp_t page_table_apply(input ptw_req_t req);
        ptw_rsp_t    rsp;
        int          tbl;
        int          child;
        int          s;
        int          lvl;
        int          i;
        logic [63:0] leaf;
        rsp.success    = 1'b1;
        rsp.phys_frame = '0;
        case (req.command)
            CMD_MAP: begin
                tbl = 0;
                for (lvl = 0; lvl < 3 && rsp.success; lvl++) begin
                    s = slot_of(tbl, req.virt_addr, lvl);
                    if (!child_table(shadow_tables[s], child)) begin
                        if (shadow_next_free >= TABLE_COUNT) begin
                            rsp.success = 1'b0;
                        end else begin
                            child = shadow_next_free;
                            shadow_next_free++;
                            for (i = 0; i < ENTRIES_PER_TABLE; i++)
                                shadow_tables[child * ENTRIES_PER_TABLE + i] = '0;
                            shadow_tables[s] = (64'(child) << 12) | ENT_WRITE | ENT_PRESENT;
                            if (lvl == 2)
                                leaf_regions.push_back(req.virt_addr[VA_W-1:21]);
                        end
                    end
                    tbl = child;
                end
                if (rsp.success) begin
                    leaf = (64'(req.frame_addr) & FRAME_MASK) | 64'(req.entry_flags)
                           | ENT_PRESENT;
                    if (req.exec_disable)
                        leaf = leaf | ENT_NOEXEC;
                    shadow_tables[slot_of(tbl, req.virt_addr, 3)] = leaf;
                end
            end
            CMD_UNMAP: begin
                if (find_leaf_table(req.virt_addr, tbl))
                    shadow_tables[slot_of(tbl, req.virt_addr, 3)] = '0;
            end
            CMD_TRANSLATE: begin
                if (find_leaf_table(req.virt_addr, tbl)) begin
                    leaf = shadow_tables[slot_of(tbl, req.virt_addr, 3)];
                    if (leaf[0])
                        rsp.phys_frame = PA_W'(leaf & FRAME_MASK);
                end
            end
            default: ;
        endcase
        return rsp;
    endfunction

    function automatic logic [VA_W-1:0] va_at(input int top, input int mid, input int dir,
                                              input int pte);
        return {9'(top), 9'(mid), 9'(dir), 9'(pte), 12'h000};
    endfunction

    function automatic ptw_req_t make_req(input logic [1:0] cmd, input logic [VA_W-1:0] va,
                                          input logic [PA_W-1:0] pa,
                                          input logic [FLAGS_W-1:0] flags, input logic nx);
        ptw_req_t req;
        req.command      = cmd;
        req.virt_addr    = va;
        req.frame_addr   = pa;
        req.entry_flags  = flags;
        req.exec_disable = nx;
        return req;
    endfunction

    // Send one request, record its expected result at the transfer
    task automatic send_request(input ptw_req_t req);
        ptw_rsp_t rsp;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= req;
        do @(posedge aclk); while (!s_ready);
        rsp = page_table_apply(req);
        expected_rsp_q.push_back(rsp);
        case (req.command)
            CMD_MAP: begin
                n_map++;
                if (!rsp.success)
                    n_map_refused++;
            end
            CMD_UNMAP:     n_unmap++;
            CMD_TRANSLATE: begin
                n_translate++;
                if (rsp.phys_frame != '0)
                    n_frames_found++;
            end
            default:       n_unused++;
        endcase
    endtask

    // Hold off the sender until every outstanding result has arrived
    task automatic wait_for_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_rsp_q.size() != 0);
    endtask

    // Compare each result transfer against the oldest expectation
    always @(posedge aclk) begin : check_results
        ptw_rsp_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_rsp_q.size() == 0) begin
                report_mismatch("result with nothing outstanding", 64'(m_payload), 64'h0);
            end else begin
                want = expected_rsp_q.pop_front();
                if (m_payload.success !== want.success)
                    report_mismatch("success", 64'(m_payload.success), 64'(want.success));
                if (m_payload.phys_frame !== want.phys_frame)
                    report_mismatch("phys_frame", 64'(m_payload.phys_frame),
                                    64'(want.phys_frame));
            end
        end
    end

    task automatic test_map_extremes();
        send_request(make_req(CMD_MAP, '0, '1, '1, 1'b1));
        send_request(make_req(CMD_TRANSLATE, 48'h0000_0000_0FFF, '0, '0, 1'b0));
        send_request(make_req(CMD_MAP, '1, '0, '0, 1'b0));
        send_request(make_req(CMD_TRANSLATE, '1, '1, '1, 1'b1));
    endtask

    task automatic test_remap_and_unmap();
        send_request(make_req(CMD_MAP, '0, 52'hA_5A5A_5A5A_5FFF, 12'h5A5, 1'b0));
        send_request(make_req(CMD_TRANSLATE, '0, '0, '0, 1'b0));
        send_request(make_req(CMD_UNMAP, '0, '0, '0, 1'b0));
        send_request(make_req(CMD_TRANSLATE, '0, '0, '0, 1'b0));
        // Unmap a page already gone, then one whose upper levels are absent
        send_request(make_req(CMD_UNMAP, '0, '0, '0, 1'b0));
        send_request(make_req(CMD_UNMAP, va_at(7, 3, 2, 1), '0, '0, 1'b0));
        send_request(make_req(CMD_TRANSLATE, va_at(7, 3, 2, 1), '0, '0, 1'b0));
    endtask

    task automatic test_unused_command();
        send_request(make_req(CMD_NONE, '1, '1, '1, 1'b1));
        send_request(make_req(CMD_NONE, '0, '0, '0, 1'b0));
    endtask

    // Drain the pool, including a refusal part-way through a walk
    task automatic test_pool_exhaustion();
        send_request(make_req(CMD_MAP, va_at(1, 0, 0, 0), 52'h1_0000, 12'h003, 1'b0));
        send_request(make_req(CMD_MAP, va_at(2, 0, 0, 0), 52'h2_0000, 12'h003, 1'b1));
        send_request(make_req(CMD_MAP, va_at(1, 5, 0, 0), 52'h3_0000, 12'h007, 1'b0));
        send_request(make_req(CMD_MAP, va_at(3, 0, 0, 0), 52'h4_0000, 12'h001, 1'b0));
        send_request(make_req(CMD_MAP, va_at(4, 0, 0, 0), 52'h5_0000, 12'h001, 1'b0));
        send_request(make_req(CMD_MAP, va_at(3, 0, 0, 0), 52'h6_0000, 12'h001, 1'b0));
        send_request(make_req(CMD_TRANSLATE, va_at(3, 0, 0, 0), '0, '0, 1'b0));
        send_request(make_req(CMD_MAP, va_at(1, 5, 0, 7), 52'h7_7000, 12'hFFF, 1'b1));
        send_request(make_req(CMD_TRANSLATE, va_at(1, 5, 0, 7), '0, '0, 1'b0));
    endtask

    // Mostly hit regions that have leaf tables, with a few stray addresses
    function automatic ptw_req_t random_request();
        ptw_req_t         req;
        int               pick;
        logic [VA_W-1:21] region;
        logic [8:0]       pte;
        pick = $urandom_range(99);
        if (pick < 40)
            req.command = CMD_MAP;
        else if (pick < 60)
            req.command = CMD_UNMAP;
        else if (pick < 95)
            req.command = CMD_TRANSLATE;
        else
            req.command = CMD_NONE;
        if ($urandom_range(99) < 85 && leaf_regions.size() != 0) begin
            region = leaf_regions[$urandom_range(leaf_regions.size() - 1)];
            pte    = ($urandom_range(99) < 70) ? 9'($urandom_range(15)) : 9'($urandom);
            req.virt_addr = {region, pte, 12'($urandom)};
        end else begin
            req.virt_addr = VA_W'({$urandom, $urandom});
        end
        req.frame_addr   = PA_W'({$urandom, $urandom});
        req.entry_flags  = FLAGS_W'($urandom);
        req.exec_disable = 1'($urandom);
        return req;
    endfunction

    task automatic test_random_traffic(input int count, input int send_pct, input int recv_pct);
        int i;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (i = 0; i < count; i++)
            send_request(random_request());
        wait_for_results();
    endtask

    initial begin
        int i;
        aclk          = 1'b0;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_payload     = '0;
        m_ready       = 1'b0;
        send_idle_pct = 25;
        recv_idle_pct = 49;
        for (i = 0; i < STORE_DEPTH; i++)
            shadow_tables[i] = '0;
        shadow_next_free = 1;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        test_map_extremes();
        test_remap_and_unmap();
        test_unused_command();
        test_pool_exhaustion();
        wait_for_results();
        test_random_traffic(RAND_ITEMS / 3, 25, 49);
        test_random_traffic(RAND_ITEMS / 3, 49, 25);
        test_random_traffic(RAND_ITEMS - 2 * (RAND_ITEMS / 3), 0, 0);

        // Let any stray result show up before closing
        repeat (TAIL_CYCLES) @(posedge aclk);
        $display("Covered %0d maps (%0d refused for want of tables), %0d unmaps, %0d translates",
                 n_map, n_map_refused, n_unmap, n_translate);
        $display("%0d translates found a frame, %0d unused codes, %0d leaf regions, %0d tables",
                 n_frames_found, n_unused, leaf_regions.size(), shadow_next_free);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
